FILE: rtl/core/tdf_pkg.sv
// ----------------------------------------------------------------------------
// tdf_pkg
// Shared constants for the trial division factorizer.
// ----------------------------------------------------------------------------
package tdf_pkg;

    localparam int VALUE_BITS_DEF = 31;
    localparam int EVEN_DIV       = 2;
    localparam int FIRST_ODD      = 3;

endpackage

FILE: rtl/core/tdf_if.sv
// ----------------------------------------------------------------------------
// tdf channel interfaces
// Valid/ready channels for the input value and the factor result words.
// ----------------------------------------------------------------------------
interface tdf_value_if
    import tdf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] value;

    modport source (output valid, output value, input ready);
    modport sink   (input valid, input value, output ready);
endinterface

interface tdf_factor_if
    import tdf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
);
    logic                  valid;
    logic                  ready;
    logic [VALUE_BITS-1:0] factor;
    logic                  last_factor;
    logic                  no_factors;

    modport source (output valid, output factor, output last_factor, output no_factors,
                    input ready);
    modport sink   (input valid, input factor, input last_factor, input no_factors,
                    output ready);
endinterface

FILE: rtl/core/trial_division_factorizer_unit.sv
// ----------------------------------------------------------------------------
// trial_division_factorizer_unit
// Prime factorization by trial division with one shared restoring divider.
// Steps: each odd trial divisor is compared (S_CHECK), divided one quotient
//   bit per cycle (S_DIV), then resolved (S_RES); factors of 2 go in S_EVEN.
// One value at a time: a new value is taken only in idle; a prime near 2^31
//   needs about 23200 trials.
// Reset (rst_n, async, active low) returns the sequencer to idle and
//   drops the output word; no clearing pass.
// ----------------------------------------------------------------------------
module trial_division_factorizer_unit
    import tdf_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    tdf_value_if.sink           value_ch,
    tdf_factor_if.source        factor_ch
);

    localparam int DIV_BITS = (VALUE_BITS + 1) / 2 + 1;
    localparam int SQ_BITS  = 2 * DIV_BITS;
    localparam int CNT_BITS = $clog2(VALUE_BITS + 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ONE   = 3'd1;
    localparam logic [2:0] S_EVEN  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_DIV   = 3'd4;
    localparam logic [2:0] S_RES   = 3'd5;

    logic [2:0]            state_reg, state_next;
    logic [VALUE_BITS-1:0] rem_reg, rem_next;
    logic [DIV_BITS-1:0]   d_reg, d_next;
    logic [SQ_BITS-1:0]    sq_reg, sq_next;
    logic [DIV_BITS-1:0]   p_reg, p_next;
    logic [VALUE_BITS-1:0] q_reg, q_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;

    logic                  out_valid_reg, out_valid_next;
    logic [VALUE_BITS-1:0] out_factor_reg, out_factor_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_none_reg, out_none_next;

    logic                  slot_free;
    logic                  emit;
    logic [DIV_BITS:0]     p_shift;
    logic [DIV_BITS:0]     p_diff;
    logic                  p_ge;
    logic [VALUE_BITS-1:0] rem_half;
    logic                  sq_le_rem;

    assign slot_free = !out_valid_reg || factor_ch.ready;

    // one quotient bit per cycle
    assign p_shift = {p_reg, q_reg[VALUE_BITS-1]};
    assign p_diff  = p_shift - {1'b0, d_reg};
    assign p_ge    = p_shift >= {1'b0, d_reg};

    assign rem_half  = rem_reg >> 1;
    assign sq_le_rem = sq_reg <= {{(SQ_BITS-VALUE_BITS){1'b0}}, rem_reg};

    always_comb
    begin
        state_next      = state_reg;
        rem_next        = rem_reg;
        d_next          = d_reg;
        sq_next         = sq_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        cnt_next        = cnt_reg;
        emit            = 1'b0;
        out_factor_next = out_factor_reg;
        out_last_next   = out_last_reg;
        out_none_next   = out_none_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (value_ch.valid)
                begin
                    rem_next   = value_ch.value;
                    state_next = (value_ch.value <= VALUE_BITS'(1)) ? S_ONE : S_EVEN;
                end
            end
            S_ONE:
            begin
                if (slot_free)
                begin
                    emit            = 1'b1;
                    out_factor_next = '0;
                    out_last_next   = 1'b1;
                    out_none_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_EVEN:
            begin
                if (rem_reg[0])
                begin
                    d_next     = DIV_BITS'(FIRST_ODD);
                    sq_next    = SQ_BITS'(FIRST_ODD * FIRST_ODD);
                    state_next = S_CHECK;
                end
                else if (slot_free)
                begin
                    emit            = 1'b1;
                    out_factor_next = VALUE_BITS'(EVEN_DIV);
                    out_last_next   = (rem_half == VALUE_BITS'(1));
                    out_none_next   = 1'b0;
                    rem_next        = rem_half;
                    if (rem_half == VALUE_BITS'(1))
                        state_next = S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (sq_le_rem)
                begin
                    p_next     = '0;
                    q_next     = rem_reg;
                    cnt_next   = CNT_BITS'(VALUE_BITS);
                    state_next = S_DIV;
                end
                else if (rem_reg <= VALUE_BITS'(1))
                begin
                    state_next = S_IDLE;
                end
                else if (slot_free)
                begin
                    // leftover is prime
                    emit            = 1'b1;
                    out_factor_next = rem_reg;
                    out_last_next   = 1'b1;
                    out_none_next   = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            S_DIV:
            begin
                p_next   = p_ge ? p_diff[DIV_BITS-1:0] : p_shift[DIV_BITS-1:0];
                q_next   = {q_reg[VALUE_BITS-2:0], p_ge};
                cnt_next = cnt_reg - CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(1))
                    state_next = S_RES;
            end
            S_RES:
            begin
                if (p_reg != '0)
                begin
                    d_next     = d_reg + DIV_BITS'(2);
                    // (d+2)^2 = d^2 + 4d + 4
                    sq_next    = sq_reg + {{(SQ_BITS-DIV_BITS-2){1'b0}}, d_reg, 2'b00}
                                 + SQ_BITS'(4);
                    state_next = S_CHECK;
                end
                else if (slot_free)
                begin
                    emit            = 1'b1;
                    out_factor_next = {{(VALUE_BITS-DIV_BITS){1'b0}}, d_reg};
                    out_last_next   = (q_reg == VALUE_BITS'(1));
                    out_none_next   = 1'b0;
                    rem_next        = q_reg;
                    state_next      = (q_reg == VALUE_BITS'(1)) ? S_IDLE : S_CHECK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (emit)
            out_valid_next = 1'b1;
        else if (factor_ch.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rem_reg       <= '0;
            d_reg         <= DIV_BITS'(EVEN_DIV);
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            rem_reg       <= rem_next;
            d_reg         <= d_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sq_reg         <= sq_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        cnt_reg        <= cnt_next;
        out_factor_reg <= out_factor_next;
        out_last_reg   <= out_last_next;
        out_none_reg   <= out_none_next;
    end

    assign value_ch.ready        = (state_reg == S_IDLE);
    assign factor_ch.valid       = out_valid_reg;
    assign factor_ch.factor      = out_factor_reg;
    assign factor_ch.last_factor = out_last_reg;
    assign factor_ch.no_factors  = out_none_reg;

    // trial divisors are odd and at least three
    a_div_odd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_DIV |-> d_reg[0] && d_reg != DIV_BITS'(1))
        else $error("trial divisor not odd");

    // the even stage leaves an odd remainder behind
    a_rem_odd: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK |-> rem_reg[0])
        else $error("even remainder reached odd trials");

    // a no-factor word is the only word of its value
    a_none_word: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_none_reg |-> out_last_reg && out_factor_reg == '0)
        else $error("malformed no-factor word");

    // the divider count is loaded with its bit count
    a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CHECK && state_next == S_DIV |=> cnt_reg == CNT_BITS'(VALUE_BITS))
        else $error("divider count not loaded");

endmodule

FILE: dv/tb_trial_division_factorizer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_trial_division_factorizer_unit
// Drives values into the factorizer and checks every factor word against a
// local trial division predictor. Both channels idle at random. One phase
// holds the result channel off while values keep coming.
// ----------------------------------------------------------------------------
module tb_trial_division_factorizer_unit
    import tdf_pkg::*;
();

    localparam int VB        = VALUE_BITS_DEF;
    localparam int RUN_LIMIT = 6_000_000;
    localparam int HOLD_LEN  = 400;

    typedef struct packed {
        logic [VB-1:0] factor;
        logic          last_factor;
        logic          no_factors;
    } factor_word_t;

    logic clk = 1'b0;
    logic rst_n;

    tdf_value_if  #(.VALUE_BITS(VB)) value_ch ();
    tdf_factor_if #(.VALUE_BITS(VB)) factor_ch ();

    trial_division_factorizer_unit #(.VALUE_BITS(VB)) i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .value_ch  (value_ch),
        .factor_ch (factor_ch)
    );

    factor_word_t factor_expect_q[$];
    int           mismatch_count = 0;
    int           cycle_count    = 0;
    logic         steady_flow    = 1'b0;
    int           hold_requests  = 0;
    int           hold_served    = 0;
    int           hold_left      = 0;

    always #5 clk = ~clk;

    function automatic void add_expected(input factor_word_t w);
        factor_expect_q = {factor_expect_q, w};
    endfunction

    // Expected factor words for one value, ascending, last one marked.
    function automatic void predict_factors(input logic [VB-1:0] v);
        logic [63:0]  rest;
        logic [63:0]  d;
        logic [63:0]  found[$];
        factor_word_t w;
        rest = 64'(v);
        if (rest <= 64'd1)
        begin
            w.factor      = '0;
            w.last_factor = 1'b1;
            w.no_factors  = 1'b1;
            add_expected(w);
            return;
        end
        while (rest[0] == 1'b0)
        begin
            found = {found, 64'(EVEN_DIV)};
            rest  = rest >> 1;
        end
        d = 64'(FIRST_ODD);
        while (d * d <= rest)
        begin
            while (rest % d == 64'd0)
            begin
                found = {found, d};
                rest  = rest / d;
            end
            d = d + 64'd2;
        end
        if (rest > 64'd1)
            found = {found, rest};
        foreach (found[i])
        begin
            w.factor      = found[i][VB-1:0];
            w.last_factor = (i == found.size() - 1);
            w.no_factors  = 1'b0;
            add_expected(w);
        end
    endfunction

    // Mostly cheap values; smooth products reach the top bits quickly.
    function automatic logic [VB-1:0] rand_value();
        int          sel;
        int          span;
        logic [63:0] prod;
        logic [63:0] f;
        logic [63:0] bound;
        sel = $urandom_range(99);
        if (sel < 45)
            return VB'($urandom_range(4095));
        if (sel < 65)
            return VB'($urandom_range(65535));
        if (sel < 70)
        begin
            span = $urandom_range(17, 20);
            return VB'($urandom & ((32'd1 << span) - 32'd1));
        end
        bound = 64'd1 << $urandom_range(16, VB);
        prod  = 64'd1;
        f     = ($urandom_range(3) == 0) ? 64'd2 : 64'($urandom_range(1, 127) * 2 + 1);
        while (prod * f < bound)
        begin
            prod = prod * f;
            f    = ($urandom_range(3) == 0) ? 64'd2 : 64'($urandom_range(1, 127) * 2 + 1);
        end
        return prod[VB-1:0];
    endfunction

    task automatic send_value(input logic [VB-1:0] v);
        while (!steady_flow && $urandom_range(99) < 22)
        begin
            value_ch.valid <= 1'b0;
            @(posedge clk);
        end
        value_ch.valid <= 1'b1;
        value_ch.value <= v;
        @(posedge clk);
        while (!value_ch.ready)
            @(posedge clk);
    endtask

    task automatic test_no_factors;
        send_value('0);
        send_value(VB'(1));
    endtask

    // Includes the all-ones value, a prime: the slowest single value.
    task automatic test_primes;
        send_value(VB'(2));
        send_value(VB'(3));
        send_value(VB'(97));
        send_value(VB'(65521));
        send_value(31'h7FFF_FFFF);
    endtask

    task automatic test_powers_of_two;
        send_value(VB'(4));
        send_value(31'h4000_0000);
    endtask

    // Odd squares land the loop exactly on d * d == remaining.
    task automatic test_square_bounds;
        send_value(VB'(9));
        send_value(VB'(25));
        send_value(VB'(49));
        send_value(VB'(63001));
    endtask

    task automatic test_composites;
        send_value(VB'(15));
        send_value(31'h7FFF_FFFE);
        send_value(VB'(1162261467));
        send_value(VB'(223092870));
        send_value(VB'(1073741825));
    endtask

    // Result channel held off; long runs of factor words fill the block.
    task automatic test_output_backpressure;
        hold_requests = hold_requests + 1;
        send_value(31'h4000_0000);
        send_value(31'h3FFF_FFFF);
        send_value(31'h2000_0000);
        send_value(VB'(1162261467));
    endtask

    task automatic test_random_values;
        repeat (60)
            send_value(rand_value());
    endtask

    task automatic test_steady_stream;
        steady_flow = 1'b1;
        repeat (20)
            send_value(rand_value());
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n          = 1'b0;
        value_ch.valid = 1'b0;
        value_ch.value = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_no_factors();
        test_primes();
        test_powers_of_two();
        test_square_bounds();
        test_composites();
        test_output_backpressure();
        test_random_values();
        test_steady_stream();
        value_ch.valid <= 1'b0;
        // let the predictor take the last word first
        @(posedge clk);
        while (factor_expect_q.size() != 0)
            @(posedge clk);
        repeat (4 * (VB + 2)) @(posedge clk);
        if (mismatch_count == 0 && factor_expect_q.size() == 0)
            $display("trial_division_factorizer_unit test passed");
        else
            $display("trial_division_factorizer_unit test failed");
        $finish;
    end

    // Receiver: random stalls, or a counted hold-off when requested.
    initial
    begin
        factor_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = HOLD_LEN;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                factor_ch.ready <= 1'b0;
            end
            else
                factor_ch.ready <= steady_flow || ($urandom_range(99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && value_ch.valid && value_ch.ready)
            predict_factors(value_ch.value);
    end

    always @(posedge clk)
    begin : check_words
        factor_word_t seen;
        factor_word_t want;
        if (rst_n && factor_ch.valid && factor_ch.ready)
        begin
            seen = {factor_ch.factor, factor_ch.last_factor, factor_ch.no_factors};
            if (factor_expect_q.size() == 0)
            begin
                $display("%0t: unexpected word: expected none, %s%0d last=%0b none=%0b",
                         $time, "actual factor=",
                         seen.factor, seen.last_factor, seen.no_factors);
                mismatch_count = mismatch_count + 1;
            end
            else
            begin
                want = factor_expect_q.pop_front();
                if (seen !== want)
                begin
                    $display("%0t: expected factor=%0d last=%0b none=%0b, %s%0d %s%0b %s%0b",
                             $time, want.factor, want.last_factor, want.no_factors,
                             "actual factor=", seen.factor,
                             "last=", seen.last_factor, "none=", seen.no_factors);
                    mismatch_count = mismatch_count + 1;
                end
            end
        end
    end

    initial
    begin
        while (cycle_count < RUN_LIMIT)
        begin
            @(posedge clk);
            cycle_count = cycle_count + 1;
        end
        $display("%0t: timeout after %0d cycles", $time, cycle_count);
        $display("trial_division_factorizer_unit test failed");
        $finish;
    end

endmodule

FILE: trial_division_factorizer_unit.f
rtl/core/tdf_pkg.sv
rtl/core/tdf_if.sv
rtl/core/trial_division_factorizer_unit.sv
dv/tb_trial_division_factorizer_unit.sv
